### rtl/lfu_ct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lfu_ct_pkg;

   // Field widths fixed by the interface
   localparam int CAP_WIDTH   = 5;
   localparam int KEY_WIDTH   = 32;
   localparam int VALUE_WIDTH = 32;

   localparam logic [CAP_WIDTH-1:0] CAP_RESET = 5'd16;

   // Operation codes
   localparam logic FUNC_GET = 1'b0;
   localparam logic FUNC_PUT = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SCAN_END,
      ST_PLAN,
      ST_UPDATE,
      ST_UPD_END,
      ST_RESULT
   } state_type;

   // Control from the sequencer to the entry store
   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic clear_all;
   } store_ctl_type;

endpackage

`default_nettype wire

### rtl/lfu_ct_store.sv
`timescale 1ns / 1ps
`default_nettype none

module lfu_ct_store #(
   parameter int CAPACITY    = 16,
   parameter int COUNT_WIDTH = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire lfu_ct_pkg::store_ctl_type             ctl,
   input  wire logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] rd_addr,
   input  wire logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] wr_addr,
   input  wire logic [lfu_ct_pkg::KEY_WIDTH-1:0]      wr_key,
   input  wire logic [lfu_ct_pkg::VALUE_WIDTH-1:0]    wr_value,
   input  wire logic [COUNT_WIDTH-1:0]                wr_count,
   input  wire logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] wr_rank,
   output logic                                       rd_valid,
   output logic [lfu_ct_pkg::KEY_WIDTH-1:0]           rd_key,
   output logic [lfu_ct_pkg::VALUE_WIDTH-1:0]         rd_value,
   output logic [COUNT_WIDTH-1:0]                     rd_count,
   output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] rd_rank
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int KW = lfu_ct_pkg::KEY_WIDTH;
   localparam int VW = lfu_ct_pkg::VALUE_WIDTH;
   localparam int EW = KW + VW + COUNT_WIDTH + AW;

   logic [EW-1:0] mem [CAPACITY];
   logic [EW-1:0] rd_word_ff;
   logic          valid_ff [CAPACITY];
   logic          rd_valid_ff;

   // Entry words: written and read in the same clocked block, read registered
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= {wr_key, wr_value, wr_count, wr_rank};
      end
      if (ctl.rd_en) begin
         rd_word_ff <= mem[rd_addr];
      end
   end

   // Valid bits: cleared at once by reset or a capacity write
   always_ff @(posedge clock) begin
      if (reset || ctl.clear_all) begin
         for (int i = 0; i < CAPACITY; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (ctl.wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_valid = rd_valid_ff;
   assign rd_key   = rd_word_ff[EW-1 -: KW];
   assign rd_value = rd_word_ff[EW-KW-1 -: VW];
   assign rd_count = rd_word_ff[AW +: COUNT_WIDTH];
   assign rd_rank  = rd_word_ff[AW-1:0];

endmodule

`default_nettype wire

### rtl/lfu_ct_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module lfu_ct_ctrl #(
   parameter int CAPACITY    = 16,
   parameter int COUNT_WIDTH = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic                                  req_func,
   input  wire logic signed [lfu_ct_pkg::KEY_WIDTH-1:0]   req_key,
   input  wire logic signed [lfu_ct_pkg::VALUE_WIDTH-1:0] req_value,
   input  wire logic                                  csr_wr_en,
   input  wire logic [lfu_ct_pkg::CAP_WIDTH-1:0]      csr_wr_data,
   output lfu_ct_pkg::store_ctl_type                  store_ctl,
   output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] rd_addr,
   output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] wr_addr,
   output logic [lfu_ct_pkg::KEY_WIDTH-1:0]           wr_key,
   output logic [lfu_ct_pkg::VALUE_WIDTH-1:0]         wr_value,
   output logic [COUNT_WIDTH-1:0]                     wr_count,
   output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] wr_rank,
   input  wire logic                                  rd_valid,
   input  wire logic [lfu_ct_pkg::KEY_WIDTH-1:0]      rd_key,
   input  wire logic [lfu_ct_pkg::VALUE_WIDTH-1:0]    rd_value,
   input  wire logic [COUNT_WIDTH-1:0]                rd_count,
   input  wire logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] rd_rank,
   input  wire logic                                  res_ready,
   output logic                                       res_load,
   output logic                                       res_hit,
   output logic signed [lfu_ct_pkg::VALUE_WIDTH-1:0]  res_read_value
);

   localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int HW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (HW > lfu_ct_pkg::CAP_WIDTH) ? HW : lfu_ct_pkg::CAP_WIDTH;
   localparam int KW   = lfu_ct_pkg::KEY_WIDTH;
   localparam int VW   = lfu_ct_pkg::VALUE_WIDTH;
   localparam logic [AW-1:0]   LAST_IDX = AW'(CAPACITY - 1);
   localparam logic [CMPW-1:0] CAP_LIM  = CMPW'(CAPACITY);

   lfu_ct_pkg::state_type state_ff, state_in;

   logic [AW-1:0]                    idx_ff;
   logic                             rd_pend_ff;
   logic [AW-1:0]                    rd_idx_ff;
   logic                             func_ff;
   logic [KW-1:0]                    key_ff;
   logic [VW-1:0]                    value_ff;
   logic [lfu_ct_pkg::CAP_WIDTH-1:0] cap_ff;
   logic [HW-1:0]                    held_ff;

   // Scan trackers
   logic                   hit_ff;
   logic [AW-1:0]          hit_idx_ff;
   logic [VW-1:0]          hit_value_ff;
   logic [COUNT_WIDTH-1:0] hit_count_ff;
   logic [AW-1:0]          hit_rank_ff;
   logic                   free_ff;
   logic [AW-1:0]          free_idx_ff;
   logic                   vic_ff;
   logic [AW-1:0]          vic_idx_ff;
   logic [COUNT_WIDTH-1:0] vic_count_ff;
   logic [AW-1:0]          vic_rank_ff;

   // Update plan
   logic [AW-1:0]          slot_ff;
   logic [AW-1:0]          gap_ff;
   logic                   gap_all_ff;
   logic [VW-1:0]          new_value_ff;
   logic [COUNT_WIDTH-1:0] new_count_ff;
   logic                   res_hit_ff;
   logic [VW-1:0]          res_value_ff;

   logic                   accept;
   logic                   idx_last;
   logic                   in_scan;
   logic                   in_upd;
   logic                   is_slot;
   logic                   bump;
   logic                   is_get;
   logic                   cap_nz;
   logic [CMPW-1:0]        cap_ext;
   logic [CMPW-1:0]        cap_eff;
   logic                   full;
   logic                   op_touch;
   logic                   op_insert;
   logic [COUNT_WIDTH-1:0] count_sat;

   assign accept   = req_valid && (state_ff == lfu_ct_pkg::ST_IDLE);
   assign idx_last = (idx_ff == LAST_IDX);

   // Decision terms, valid in the plan state
   assign is_get    = (func_ff == lfu_ct_pkg::FUNC_GET);
   assign cap_nz    = (cap_ff != '0);
   assign cap_ext   = CMPW'(cap_ff);
   assign cap_eff   = (cap_ext > CAP_LIM) ? CAP_LIM : cap_ext;
   assign full      = (CMPW'(held_ff) >= cap_eff);
   assign op_touch  = hit_ff && (is_get || cap_nz);
   assign op_insert = !is_get && cap_nz && !hit_ff;
   assign count_sat = (hit_count_ff == '1) ? hit_count_ff
                                           : COUNT_WIDTH'(hit_count_ff + 1'b1);

   // Returned entry handling in each pass
   assign in_scan = rd_pend_ff && ((state_ff == lfu_ct_pkg::ST_SCAN) ||
                                   (state_ff == lfu_ct_pkg::ST_SCAN_END));
   assign in_upd  = rd_pend_ff && ((state_ff == lfu_ct_pkg::ST_UPDATE) ||
                                   (state_ff == lfu_ct_pkg::ST_UPD_END));
   assign is_slot = (rd_idx_ff == slot_ff);
   assign bump    = rd_valid && (gap_all_ff || (rd_rank < gap_ff));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lfu_ct_pkg::ST_IDLE: begin
            if (req_valid) state_in = lfu_ct_pkg::ST_SCAN;
         end
         lfu_ct_pkg::ST_SCAN: begin
            if (idx_last) state_in = lfu_ct_pkg::ST_SCAN_END;
         end
         lfu_ct_pkg::ST_SCAN_END: begin
            state_in = lfu_ct_pkg::ST_PLAN;
         end
         lfu_ct_pkg::ST_PLAN: begin
            state_in = (op_touch || op_insert) ? lfu_ct_pkg::ST_UPDATE
                                               : lfu_ct_pkg::ST_RESULT;
         end
         lfu_ct_pkg::ST_UPDATE: begin
            if (idx_last) state_in = lfu_ct_pkg::ST_UPD_END;
         end
         lfu_ct_pkg::ST_UPD_END: begin
            state_in = lfu_ct_pkg::ST_RESULT;
         end
         lfu_ct_pkg::ST_RESULT: begin
            if (res_ready) state_in = lfu_ct_pkg::ST_IDLE;
         end
         default: begin
            state_in = lfu_ct_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall           = (state_ff != lfu_ct_pkg::ST_IDLE);
      res_load            = (state_ff == lfu_ct_pkg::ST_RESULT) && res_ready;
      store_ctl.rd_en     = (state_ff == lfu_ct_pkg::ST_SCAN) ||
                            (state_ff == lfu_ct_pkg::ST_UPDATE);
      store_ctl.wr_en     = in_upd && (is_slot || bump);
      store_ctl.clear_all = csr_wr_en;
      rd_addr             = idx_ff;
      wr_addr             = rd_idx_ff;
      wr_key              = is_slot ? key_ff : rd_key;
      wr_value            = is_slot ? new_value_ff : rd_value;
      wr_count            = is_slot ? new_count_ff : rd_count;
      wr_rank             = is_slot ? '0 : AW'(rd_rank + 1'b1);
   end

   assign res_hit        = res_hit_ff;
   assign res_read_value = res_value_ff;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= lfu_ct_pkg::ST_IDLE;
         rd_pend_ff <= 1'b0;
         cap_ff     <= lfu_ct_pkg::CAP_RESET;
         held_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         rd_pend_ff <= store_ctl.rd_en;
         if (csr_wr_en) begin
            cap_ff  <= csr_wr_data;
            held_ff <= '0;
         end else if ((state_ff == lfu_ct_pkg::ST_PLAN) && op_insert && !full) begin
            held_ff <= HW'(held_ff + 1'b1);
         end
      end
   end

   // Sweep index and transaction capture
   always_ff @(posedge clock) begin
      rd_idx_ff <= idx_ff;
      if (accept) begin
         idx_ff   <= '0;
         func_ff  <= req_func;
         key_ff   <= req_key;
         value_ff <= req_value;
      end else if (store_ctl.rd_en) begin
         idx_ff <= idx_last ? '0 : AW'(idx_ff + 1'b1);
      end
   end

   // Key search, first free entry and eviction candidate over the first pass
   always_ff @(posedge clock) begin
      if (accept) begin
         hit_ff  <= 1'b0;
         free_ff <= 1'b0;
         vic_ff  <= 1'b0;
      end else if (in_scan) begin
         if (rd_valid && (rd_key == key_ff) && !hit_ff) begin
            hit_ff       <= 1'b1;
            hit_idx_ff   <= rd_idx_ff;
            hit_value_ff <= rd_value;
            hit_count_ff <= rd_count;
            hit_rank_ff  <= rd_rank;
         end
         if (!rd_valid && !free_ff) begin
            free_ff     <= 1'b1;
            free_idx_ff <= rd_idx_ff;
         end
         if (rd_valid && (!vic_ff || (rd_count < vic_count_ff) ||
                          ((rd_count == vic_count_ff) && (rd_rank > vic_rank_ff)))) begin
            vic_ff       <= 1'b1;
            vic_idx_ff   <= rd_idx_ff;
            vic_count_ff <= rd_count;
            vic_rank_ff  <= rd_rank;
         end
      end
   end

   // Plan the second pass and the result
   always_ff @(posedge clock) begin
      if (state_ff == lfu_ct_pkg::ST_PLAN) begin
         slot_ff      <= op_touch ? hit_idx_ff : (full ? vic_idx_ff : free_idx_ff);
         gap_ff       <= op_touch ? hit_rank_ff : vic_rank_ff;
         gap_all_ff   <= !op_touch && !full;
         new_value_ff <= is_get ? hit_value_ff : value_ff;
         new_count_ff <= op_touch ? count_sat : COUNT_WIDTH'(1);
         res_hit_ff   <= op_touch;
         res_value_ff <= (is_get && hit_ff) ? hit_value_ff : '0;
      end
   end

endmodule

`default_nettype wire

### rtl/lfu_cache_table_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Handshake              Payload
// req      in   req_valid / req_stall  req_func, req_key, req_value
// rsp      out  rsp_valid / rsp_stall  rsp_hit, rsp_read_value
// csr      in   csr_wr_en              csr_wr_data (cache capacity)
//
// A transaction that bumps or inserts an entry sweeps the entries twice between
// accepts; a get miss or an ignored put sweeps them once.
// One sweep reads every entry for the key and eviction candidate, a second rewrites ranks.
// Synchronous reset clears the valid bits and fill count and loads capacity 16;
// a capacity write empties the cache. A stalled result waits in the output
// register while the next transaction runs; the sequencer holds only if it is full.

module lfu_cache_table_unit #(
   parameter int CAPACITY    = 16,
   parameter int COUNT_WIDTH = 16
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      req_valid,
   output logic                                           req_stall,
   input  wire logic                                      req_func,
   input  wire logic signed [lfu_ct_pkg::KEY_WIDTH-1:0]   req_key,
   input  wire logic signed [lfu_ct_pkg::VALUE_WIDTH-1:0] req_value,
   output logic                                           rsp_valid,
   input  wire logic                                      rsp_stall,
   output logic                                           rsp_hit,
   output logic signed [lfu_ct_pkg::VALUE_WIDTH-1:0]      rsp_read_value,
   input  wire logic                                      csr_wr_en,
   input  wire logic [lfu_ct_pkg::CAP_WIDTH-1:0]          csr_wr_data
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int KW = lfu_ct_pkg::KEY_WIDTH;
   localparam int VW = lfu_ct_pkg::VALUE_WIDTH;

   lfu_ct_pkg::store_ctl_type store_ctl;

   logic [AW-1:0]          rd_addr;
   logic [AW-1:0]          wr_addr;
   logic [KW-1:0]          wr_key;
   logic [VW-1:0]          wr_value;
   logic [COUNT_WIDTH-1:0] wr_count;
   logic [AW-1:0]          wr_rank;
   logic                   rd_valid;
   logic [KW-1:0]          rd_key;
   logic [VW-1:0]          rd_value;
   logic [COUNT_WIDTH-1:0] rd_count;
   logic [AW-1:0]          rd_rank;

   logic                   res_ready;
   logic                   res_load;
   logic                   res_hit;
   logic signed [VW-1:0]   res_read_value;

   logic                   rsp_valid_ff;
   logic                   rsp_hit_ff;
   logic signed [VW-1:0]   rsp_read_value_ff;

   lfu_ct_ctrl #(
      .CAPACITY    (CAPACITY),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_key        (req_key),
      .req_value      (req_value),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .store_ctl      (store_ctl),
      .rd_addr        (rd_addr),
      .wr_addr        (wr_addr),
      .wr_key         (wr_key),
      .wr_value       (wr_value),
      .wr_count       (wr_count),
      .wr_rank        (wr_rank),
      .rd_valid       (rd_valid),
      .rd_key         (rd_key),
      .rd_value       (rd_value),
      .rd_count       (rd_count),
      .rd_rank        (rd_rank),
      .res_ready      (res_ready),
      .res_load       (res_load),
      .res_hit        (res_hit),
      .res_read_value (res_read_value)
   );

   lfu_ct_store #(
      .CAPACITY    (CAPACITY),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .ctl      (store_ctl),
      .rd_addr  (rd_addr),
      .wr_addr  (wr_addr),
      .wr_key   (wr_key),
      .wr_value (wr_value),
      .wr_count (wr_count),
      .wr_rank  (wr_rank),
      .rd_valid (rd_valid),
      .rd_key   (rd_key),
      .rd_value (rd_value),
      .rd_count (rd_count),
      .rd_rank  (rd_rank)
   );

   // Result register: load when empty or when the held transaction drains now
   assign res_ready = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Hold payload while stalled
   always_ff @(posedge clock) begin
      if (res_load) begin
         rsp_hit_ff        <= res_hit;
         rsp_read_value_ff <= res_read_value;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_read_value = rsp_read_value_ff;

endmodule

`default_nettype wire

### tb/tb_lfu_cache_table_unit.sv
`timescale 1ns / 1ps

module tb_lfu_cache_table_unit;

   // Entry count of the block under test, and a narrow use counter so that
   // count saturation shows up within a short run.
   localparam int SLOTS          = 16;
   localparam int USE_COUNT_BITS = 4;
   localparam int KW             = lfu_ct_pkg::KEY_WIDTH;
   localparam int VW             = lfu_ct_pkg::VALUE_WIDTH;
   localparam int CW             = lfu_ct_pkg::CAP_WIDTH;
   // Slowest transaction: one sweep to find key and victim, one to rewrite ranks.
   localparam int BUSY_CYCLES    = 2 * SLOTS + 5;

   localparam logic signed [KW-1:0] KEY_MAX = 32'sh7fff_ffff;
   localparam logic signed [KW-1:0] KEY_MIN = 32'sh8000_0000;

   typedef struct {
      logic                 func;
      logic signed [KW-1:0] key;
      logic signed [VW-1:0] value;
   } cache_req_type;

   typedef struct {
      logic                 hit;
      logic signed [VW-1:0] read_value;
   } cache_rsp_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_func = lfu_ct_pkg::FUNC_GET;
   logic signed [KW-1:0] req_key = '0;
   logic signed [VW-1:0] req_value = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic                 rsp_hit;
   logic signed [VW-1:0] rsp_read_value;
   logic                 csr_wr_en = 1'b0;
   logic [CW-1:0]        csr_wr_data = '0;

   lfu_cache_table_unit #(
      .CAPACITY   (SLOTS),
      .COUNT_WIDTH(USE_COUNT_BITS)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_func      (req_func),
      .req_key       (req_key),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_hit       (rsp_hit),
      .rsp_read_value(rsp_read_value),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Shadow copy of the cache contents
   logic [CW-1:0]             shadow_capacity = lfu_ct_pkg::CAP_RESET;
   bit                        slot_valid [SLOTS];
   logic signed [KW-1:0]      slot_key   [SLOTS];
   logic signed [VW-1:0]      slot_value [SLOTS];
   logic [USE_COUNT_BITS-1:0] slot_uses  [SLOTS];
   int unsigned               slot_rank  [SLOTS];
   int unsigned               slots_held = 0;

   cache_req_type req_backlog [$];
   cache_rsp_type predicted_rsps [$];

   int  reqs_taken   = 0;
   int  results_seen = 0;
   int  mismatches   = 0;
   int  hold_left    = 0;
   bit  held_once    = 1'b0;

   // Empty the shadow store, as reset and every capacity write do.
   function automatic void wipe_slots();
      for (int i = 0; i < SLOTS; i++) begin
         slot_valid[i] = 1'b0;
      end
      slots_held = 0;
   endfunction

   // Make a slot the most recent and bump its count, holding at the top.
   function automatic void touch_slot(int slot);
      int unsigned r;
      r = slot_rank[slot];
      for (int j = 0; j < SLOTS; j++) begin
         if (slot_valid[j] && slot_rank[j] < r) slot_rank[j]++;
      end
      slot_rank[slot] = 0;
      if (slot_uses[slot] != '1) slot_uses[slot]++;
   endfunction

   // Insert a new key, evicting the least used (oldest on a tie) when full.
   function automatic void place_key(logic signed [KW-1:0] k,
                                     logic signed [VW-1:0] v, int unsigned cap);
      int          slot;
      int unsigned gap;
      slot = -1;
      gap  = 32'hffff_ffff;
      if (slots_held >= cap) begin
         for (int i = 0; i < SLOTS; i++) begin
            if (!slot_valid[i]) continue;
            if (slot < 0 || slot_uses[i] < slot_uses[slot] ||
                (slot_uses[i] == slot_uses[slot] && slot_rank[i] > slot_rank[slot]))
               slot = i;
         end
         if (slot < 0) return;
         gap = slot_rank[slot];
         slot_valid[slot] = 1'b0;
         slots_held--;
      end else begin
         for (int i = 0; i < SLOTS; i++) begin
            if (!slot_valid[i]) begin
               slot = i;
               break;
            end
         end
         if (slot < 0) return;
      end
      for (int i = 0; i < SLOTS; i++) begin
         if (slot_valid[i] && slot_rank[i] < gap) slot_rank[i]++;
      end
      slot_valid[slot] = 1'b1;
      slot_key[slot]   = k;
      slot_value[slot] = v;
      slot_uses[slot]  = 1;
      slot_rank[slot]  = 0;
      slots_held++;
   endfunction

   // Work out the answer to one get or put and advance the shadow store.
   function automatic cache_rsp_type cache_access(cache_req_type item);
      cache_rsp_type rsp;
      int            slot;
      int unsigned   cap;
      rsp.hit        = 1'b0;
      rsp.read_value = '0;
      slot = -1;
      cap  = (shadow_capacity > SLOTS) ? SLOTS : shadow_capacity;
      for (int i = 0; i < SLOTS; i++) begin
         if (slot_valid[i] && slot_key[i] == item.key) begin
            slot = i;
            break;
         end
      end
      if (item.func == lfu_ct_pkg::FUNC_GET) begin
         if (slot >= 0) begin
            rsp.hit        = 1'b1;
            rsp.read_value = slot_value[slot];
            touch_slot(slot);
         end
      end else if (cap != 0) begin
         if (slot >= 0) begin
            rsp.hit          = 1'b1;
            slot_value[slot] = item.value;
            touch_slot(slot);
         end else begin
            place_key(item.key, item.value, cap);
         end
      end
      return rsp;
   endfunction

   function automatic void log_mismatch(string msg);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
   endfunction

   function automatic void queue_req(logic f, logic signed [KW-1:0] k,
                                     logic signed [VW-1:0] v);
      cache_req_type item;
      item.func  = f;
      item.key   = k;
      item.value = v;
      req_backlog.insert(req_backlog.size(), item);
   endfunction

   // Request driver: predict on every accepted transaction, then advance to
   // the next queued item unless this cycle idles. A stalled item is held.
   always @(posedge clock) begin
      bit            calm;
      cache_req_type item;
      calm = (reqs_taken >= 900 && reqs_taken < 1200);
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            item.func  = req_func;
            item.key   = req_key;
            item.value = req_value;
            predicted_rsps.insert(predicted_rsps.size(), cache_access(item));
            reqs_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (req_backlog.size() != 0 && (calm || $urandom_range(99) >= 6)) begin
               item = req_backlog[0];
               req_backlog.delete(0);
               req_func  <= item.func;
               req_key   <= item.key;
               req_value <= item.value;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: compare each accepted result with the oldest prediction,
   // and drive the stall, with one long hold-off while requests keep coming.
   always @(posedge clock) begin
      bit            calm;
      cache_rsp_type want;
      calm = (results_seen >= 900 && results_seen < 1200);
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (predicted_rsps.size() == 0) begin
               log_mismatch($sformatf("unexpected result hit=%0b read_value=%0d",
                                      rsp_hit, rsp_read_value));
            end else begin
               want = predicted_rsps[0];
               predicted_rsps.delete(0);
               if (rsp_hit !== want.hit)
                  log_mismatch($sformatf("hit expected %0b actual %0b", want.hit, rsp_hit));
               if (rsp_read_value !== want.read_value)
                  log_mismatch($sformatf("read_value expected %0d actual %0d",
                                         want.read_value, rsp_read_value));
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (!held_once && results_seen >= 250 && req_backlog.size() > 40) begin
            held_once = 1'b1;
            hold_left = 400;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !calm && ($urandom_range(99) < 6);
         end
      end
   end

   // Wait until every queued request has gone in and its result came back.
   task automatic drain();
      while (req_backlog.size() != 0 || req_valid || predicted_rsps.size() != 0)
         @(posedge clock);
   endtask

   // Write the capacity register once the block has gone quiet.
   task automatic set_capacity(logic [CW-1:0] cap);
      drain();
      repeat (BUSY_CYCLES + 3) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cap;
      @(posedge clock);
      shadow_capacity = cap;
      wipe_slots();
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // Random traffic over a key set sized to the capacity, so hits, updates,
   // evictions and saturated counts are all common; a few keys are wild.
   task automatic run_random(int count, int cap);
      logic signed [KW-1:0] key_pool [$];
      logic signed [KW-1:0] k;
      int                   pick;
      int                   pool_size;
      pool_size = (cap > SLOTS ? SLOTS : cap) * 2 + 2;
      for (int i = 0; i < pool_size; i++) key_pool.insert(key_pool.size(), $urandom);
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            k = $urandom;
         end else if (pick < 12) begin
            case ($urandom_range(3))
               0: k = KEY_MAX;
               1: k = KEY_MIN;
               2: k = '0;
               default: k = '1;
            endcase
         end else begin
            k = key_pool[$urandom_range(pool_size - 1)];
         end
         queue_req(($urandom_range(99) < 45) ? lfu_ct_pkg::FUNC_PUT : lfu_ct_pkg::FUNC_GET,
                   k, $urandom);
      end
   endtask

   initial begin
      for (int i = 0; i < SLOTS; i++) begin
         slot_valid[i] = 1'b0;
         slot_key[i]   = '0;
         slot_value[i] = '0;
         slot_uses[i]  = '0;
         slot_rank[i]  = 0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Full capacity after reset: extreme keys and values, update, misses
      queue_req(lfu_ct_pkg::FUNC_GET, '0, '0);
      queue_req(lfu_ct_pkg::FUNC_PUT, KEY_MAX, KEY_MIN);
      queue_req(lfu_ct_pkg::FUNC_PUT, KEY_MIN, KEY_MAX);
      queue_req(lfu_ct_pkg::FUNC_PUT, '0, '1);
      queue_req(lfu_ct_pkg::FUNC_PUT, '1, '0);
      queue_req(lfu_ct_pkg::FUNC_GET, KEY_MAX, '1);
      queue_req(lfu_ct_pkg::FUNC_GET, KEY_MIN, '0);
      queue_req(lfu_ct_pkg::FUNC_GET, '0, '0);
      queue_req(lfu_ct_pkg::FUNC_PUT, '1, 32'sh5a5a_a5a5);
      queue_req(lfu_ct_pkg::FUNC_GET, '1, '0);
      queue_req(lfu_ct_pkg::FUNC_GET, 32'sd7, '0);
      run_random(100, SLOTS);
      // Pause the sender until every result is back, then go on.
      drain();
      run_random(100, SLOTS);

      // Capacity zero: puts are dropped and everything misses
      set_capacity(5'd0);
      queue_req(lfu_ct_pkg::FUNC_PUT, 32'sd11, 32'sd99);
      queue_req(lfu_ct_pkg::FUNC_GET, 32'sd11, '0);
      run_random(100, 0);

      // Capacity one: every new key evicts the only entry
      set_capacity(5'd1);
      queue_req(lfu_ct_pkg::FUNC_PUT, 32'sd1, 32'sd100);
      queue_req(lfu_ct_pkg::FUNC_PUT, 32'sd2, 32'sd200);
      queue_req(lfu_ct_pkg::FUNC_GET, 32'sd1, '0);
      queue_req(lfu_ct_pkg::FUNC_GET, 32'sd2, '0);
      run_random(180, 1);

      // Capacity two: equal counts evict the oldest, then the lowest count goes
      set_capacity(5'd2);
      queue_req(lfu_ct_pkg::FUNC_PUT, 32'sd1, 32'sd10);
      queue_req(lfu_ct_pkg::FUNC_PUT, 32'sd2, 32'sd20);
      queue_req(lfu_ct_pkg::FUNC_PUT, 32'sd3, 32'sd30);
      queue_req(lfu_ct_pkg::FUNC_GET, 32'sd2, '0);
      queue_req(lfu_ct_pkg::FUNC_PUT, 32'sd4, 32'sd40);
      queue_req(lfu_ct_pkg::FUNC_GET, 32'sd3, '0);
      queue_req(lfu_ct_pkg::FUNC_GET, 32'sd1, '0);
      run_random(200, 2);

      set_capacity(5'd3);
      run_random(200, 3);
      set_capacity(5'd5);
      run_random(200, 5);
      set_capacity(5'd8);
      run_random(200, 8);
      // Above the entry count: the block uses all of its entries
      set_capacity(5'd31);
      run_random(200, 31);
      set_capacity(5'd17);
      run_random(150, 17);
      set_capacity(5'd16);
      run_random(150, 16);

      drain();
      repeat (BUSY_CYCLES + 3) @(posedge clock);
      if (mismatches == 0 && predicted_rsps.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Hard stop, well past the slowest correct run
   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

endmodule

### lfu_cache_table_unit.f
rtl/lfu_ct_pkg.sv
rtl/lfu_ct_store.sv
rtl/lfu_ct_ctrl.sv
rtl/lfu_cache_table_unit.sv
tb/tb_lfu_cache_table_unit.sv
